[design/fac_pkg.sv]
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types, widths and helper functions for the frustum box culling unit.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int COORD_W        = 16;
  localparam int SUM_W          = COORD_W + 1;
  localparam int PROD_W         = 2 * SUM_W;
  localparam int ACC_W          = PROD_W + 4;
  localparam int W_SHIFT        = 15;
  localparam int AXES           = 3;
  localparam int AXIS_W         = 2;
  localparam int PLANE_W        = 64;
  localparam int REG_COUNT      = 6;
  localparam int REG_IDX_W      = 3;
  localparam int ADDR_W         = 6;
  localparam int ADDR_LSB       = 3;
  localparam int NUM_PLANES_DEF = 6;
  localparam int VERDICT_W      = 2;

  localparam logic [VERDICT_W-1:0] VERDICT_INSIDE    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_INTERSECT = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE   = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_RSVD      = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  typedef struct packed {
    logic prod;
    logic acc;
  } stage_en_t;

  typedef struct packed {
    logic contained;
    logic outside;
  } plane_class_t;

  function automatic coord_t plane_normal(input logic [PLANE_W-1:0] r,
                                          input logic [AXIS_W-1:0] axis);
    return r[axis*COORD_W +: COORD_W];
  endfunction

  function automatic coord_t plane_offset(input logic [PLANE_W-1:0] r);
    return r[PLANE_W-1 -: COORD_W];
  endfunction

endpackage

[design/fac_plane_regs.sv]
// ----------------------------------------------------------------------------
// fac_plane_regs
// Register file holding the six packed frustum planes behind an APB-style port.
// ----------------------------------------------------------------------------
module fac_plane_regs (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               psel,
  input  logic                                               penable,
  input  logic                                               pwrite,
  input  logic [fac_pkg::ADDR_W-1:0]                         paddr,
  input  logic [fac_pkg::PLANE_W-1:0]                        pwdata,
  output logic [fac_pkg::PLANE_W-1:0]                        prdata,
  output logic                                               pready,
  output logic [fac_pkg::REG_COUNT-1:0][fac_pkg::PLANE_W-1:0] planes
);
  import fac_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 idx_ok;

  assign idx    = paddr[ADDR_W-1:ADDR_LSB];
  assign idx_ok = idx < REG_IDX_W'(REG_COUNT);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      planes <= '0;
    end else if (psel && penable && pwrite && idx_ok) begin
      planes[idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = planes[idx];
    end
  end

endmodule

[design/fac_plane_eval.sv]
// ----------------------------------------------------------------------------
// fac_plane_eval
// Two-stage test of one box against one plane: products, then center and
// extent sums, with the inside and outside decisions taken from the sums.
// ----------------------------------------------------------------------------
module fac_plane_eval (
  input  logic                         clk,
  input  fac_pkg::stage_en_t           en,
  input  logic [fac_pkg::PLANE_W-1:0]  plane,
  input  fac_pkg::sum_t                sum [fac_pkg::AXES],
  input  fac_pkg::sum_t                ext [fac_pkg::AXES],
  output fac_pkg::plane_class_t        cls
);
  import fac_pkg::*;

  coord_t n     [AXES];
  sum_t   n_abs [AXES];
  coord_t w;
  prod_t  sprod [AXES];
  prod_t  eprod [AXES];
  coord_t w_reg;
  acc_t   s_next;
  acc_t   e_next;
  acc_t   s_acc;
  acc_t   e_acc;
  acc_t   diff;
  acc_t   total;

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      n[k]     = plane_normal(plane, AXIS_W'(k));
      n_abs[k] = n[k][COORD_W-1] ? -SUM_W'(n[k]) : SUM_W'(n[k]);
    end
    w = plane_offset(plane);
  end

  always_ff @(posedge clk) begin
    if (en.prod) begin
      for (int k = 0; k < AXES; k++) begin
        sprod[k] <= PROD_W'(n[k]) * PROD_W'(sum[k]);
        eprod[k] <= PROD_W'(n_abs[k]) * PROD_W'(ext[k]);
      end
      w_reg <= w;
    end
  end

  always_comb begin
    s_next = ACC_W'(w_reg) <<< W_SHIFT;
    e_next = '0;
    for (int k = 0; k < AXES; k++) begin
      s_next = s_next + ACC_W'(sprod[k]);
      e_next = e_next + ACC_W'(eprod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.acc) begin
      s_acc <= s_next;
      e_acc <= e_next;
    end
  end

  // With a negative extent both tests can pass; the inside test wins.
  assign diff          = s_acc - e_acc;
  assign total         = s_acc + e_acc;
  assign cls.contained = diff > ACC_W'(0);
  assign cls.outside   = (total < ACC_W'(0)) && !(diff > ACC_W'(0));

endmodule

[design/frustum_aabb_cull_unit.sv]
// ----------------------------------------------------------------------------
// frustum_aabb_cull_unit
// Classifies each box as inside, intersecting or outside the frustum.
// A box passes through four register stages: center sums and extents,
// products, plane sums and the verdict register, each with its own valid bit.
// Throughput is one box per cycle unless a low out_ready holds the pipeline.
// Reset clears all stage valid bits and sets every plane register to zero.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_unit #(
  parameter int NUM_PLANES = fac_pkg::NUM_PLANES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fac_pkg::ADDR_W-1:0]          paddr,
  input  logic [fac_pkg::PLANE_W-1:0]         pwdata,
  output logic [fac_pkg::PLANE_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [fac_pkg::COORD_W-1:0]  min_x,
  input  logic signed [fac_pkg::COORD_W-1:0]  min_y,
  input  logic signed [fac_pkg::COORD_W-1:0]  min_z,
  input  logic signed [fac_pkg::COORD_W-1:0]  max_x,
  input  logic signed [fac_pkg::COORD_W-1:0]  max_y,
  input  logic signed [fac_pkg::COORD_W-1:0]  max_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fac_pkg::VERDICT_W-1:0]       verdict
);
  import fac_pkg::*;

  localparam int ACTIVE = (NUM_PLANES > REG_COUNT) ? REG_COUNT : NUM_PLANES;

  logic [REG_COUNT-1:0][PLANE_W-1:0] planes;
  coord_t       lo   [AXES];
  coord_t       hi   [AXES];
  sum_t         sum1 [AXES];
  sum_t         ext1 [AXES];
  logic         v1;
  logic         v2;
  logic         v3;
  logic         v4;
  logic         rdy1;
  logic         rdy2;
  logic         rdy3;
  logic         rdy4;
  stage_en_t    en;
  plane_class_t cls [ACTIVE];
  logic         any_out;
  logic         any_mid;
  logic [VERDICT_W-1:0] verdict_next;

  fac_plane_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .planes  (planes)
  );

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign en.prod  = rdy2 && v1;
  assign en.acc   = rdy3 && v2;

  assign lo[0] = min_x;
  assign lo[1] = min_y;
  assign lo[2] = min_z;
  assign hi[0] = max_x;
  assign hi[1] = max_y;
  assign hi[2] = max_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      for (int k = 0; k < AXES; k++) begin
        sum1[k] <= SUM_W'(hi[k]) + SUM_W'(lo[k]);
        ext1[k] <= SUM_W'(hi[k]) - SUM_W'(lo[k]);
      end
    end
  end

  for (genvar p = 0; p < ACTIVE; p++) begin : g_plane
    fac_plane_eval u_eval (
      .clk   (clk),
      .en    (en),
      .plane (planes[p]),
      .sum   (sum1),
      .ext   (ext1),
      .cls   (cls[p])
    );
  end

  always_comb begin
    any_out = 1'b0;
    any_mid = 1'b0;
    for (int p = 0; p < ACTIVE; p++) begin
      any_out = any_out || cls[p].outside;
      any_mid = any_mid || (!cls[p].outside && !cls[p].contained);
    end
    if (any_out) begin
      verdict_next = VERDICT_OUTSIDE;
    end else if (any_mid) begin
      verdict_next = VERDICT_INTERSECT;
    end else begin
      verdict_next = VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      verdict <= verdict_next;
    end
  end

  assign out_valid = v4;

  a_no_rsvd_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> verdict != VERDICT_RSVD)
    else $error("reserved verdict code on a valid result");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted box did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v4 && !out_ready && v3 |=> v3 && v4)
    else $error("stalled pipeline dropped an item");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v1 && !v2 && !v3 && !v4 |-> in_ready)
    else $error("empty pipeline refused a transfer");

endmodule
